FILE: rtl/wsfd_pkg.sv
// Shared types, constants and the soft-clip curve table for the waveshaper with feedback delay.
// Standalone; used by every module of the block.
package wsfd_pkg;

	// Sample format and storage sizes
	localparam int SAMPLE_BITS     = 24;
	localparam int DELAY_DEPTH     = 131072;
	localparam int EXP_TABLE_DEPTH = 1024;

	localparam int  AW   = $clog2(DELAY_DEPTH);         // ring address bits
	localparam int  TAW  = $clog2(EXP_TABLE_DEPTH + 1); // curve table address bits
	localparam int  VW   = SAMPLE_BITS + 4;             // driven value, |v| < 16*ONE
	localparam int  SW   = VW + 1;                      // shaped value
	localparam int  MA_W = SW;                          // shared multiplier, port A
	localparam int  MB_W = SAMPLE_BITS + 1;             // shared multiplier, port B
	localparam int  PW   = MA_W + MB_W;                 // product
	localparam longint ONE = longint'(1) << (SAMPLE_BITS - 1);

	// Drive gain is unsigned Q4.12
	localparam int DRIVE_FRAC = 12;
	// Mix weights are unsigned Q1.15
	localparam int MIX_FRAC   = 15;

	// Curve table lookup: index and 16-bit interpolation fraction from |v|
	localparam int TSHIFT    = SAMPLE_BITS + 3;
	localparam int EXP_LOG   = $clog2(EXP_TABLE_DEPTH);
	localparam int IDX_SHIFT = TSHIFT - EXP_LOG;
	localparam int IW        = VW - IDX_SHIFT;

	// Quadratic curve: floor((d*d + 3*ONE/2) / (3*ONE)) = floor(q / 3),
	// q = (d*d + 3*ONE/2) >> (SAMPLE_BITS-1); q/3 by reciprocal multiply
	localparam longint Q_BIAS      = (longint'(3) << (SAMPLE_BITS - 2));
	localparam int     RECIP_SHIFT = SAMPLE_BITS + 1;
	localparam longint RECIP3      = ((longint'(1) << RECIP_SHIFT) + 2) / 3;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int QAW     = $clog2(Q_DEPTH);

	// Configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 17;

	localparam logic [CFG_IW-1:0] CFG_MODE     = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_DRIVE    = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_DLY_EN   = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DLY_LEN  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_DRY      = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_WET      = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_FEEDBACK = 3'd6;

	// Distortion mode codes; anything else is bypass
	localparam logic [2:0] MODE_FULL = 3'd2;
	localparam logic [2:0] MODE_HALF = 3'd3;
	localparam logic [2:0] MODE_HARD = 3'd4;
	localparam logic [2:0] MODE_QUAD = 3'd5;
	localparam logic [2:0] MODE_EXP  = 3'd6;

	typedef struct packed {
		logic [2:0]  distortion_mode;
		logic [15:0] drive_gain;
		logic        delay_enable;
		logic [16:0] delay_samples;
		logic [15:0] dry_mix;
		logic [15:0] wet_mix;
		logic [15:0] feedback_gain;
	} cfg_t;

	// Where 3v falls for the quadratic curve
	typedef enum logic [2:0] {
		RG_MID,
		RG_POS_CURVE,
		RG_POS_SAT,
		RG_NEG_CURVE,
		RG_NEG_SAT
	} region_t;

	typedef struct packed {
		logic signed [VW-1:0] v_l;
		logic signed [VW-1:0] v_r;
		region_t              rg_l;
		region_t              rg_r;
	} q_entry_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LOAD,
		B_SH0,
		B_SH1,
		B_SH2,
		B_SH3,
		B_MIX0,
		B_MIX1,
		B_MIX2,
		B_MIX3,
		B_DONE
	} back_state_t;

	typedef logic [SAMPLE_BITS-1:0] exp_tab_t [EXP_TABLE_DEPTH+1];

	// Restoring division of a non-negative value, used for the series terms
	function automatic longint udiv(input longint n, input longint d);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r << 1) | ((n >>> b) & longint'(1));
			if (r >= d) begin
				r = r - d;
				q = q | (longint'(1) << b);
			end
		end
		return q;
	endfunction

	// Entry k = ONE - round(ONE * e^(-16k/DEPTH)); e^(-z) by a 20-term series in Q31,
	// then squared four times.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		longint   z;
		longint   term;
		longint   sum;
		for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
			z    = (longint'(k) << 31) >> EXP_LOG;
			term = longint'(1) << 31;
			sum  = term;
			for (int i = 1; i <= 20; i++) begin
				term = udiv((term * z) >>> 31, longint'(i));
				if ((i & 1) != 0)
					sum = sum - term;
				else
					sum = sum + term;
			end
			if (sum < 0)
				sum = 0;
			for (int j = 0; j < 4; j++)
				sum = (sum * sum + (longint'(1) << 30)) >>> 31;
			tab[k] = SAMPLE_BITS'(ONE - ((sum * ONE + (longint'(1) << 30)) >>> 31));
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: rtl/wsfd_front.sv
// Front end: takes input frames, applies the drive gain and classifies each sample.
// Depends on wsfd_pkg; feeds wsfd_queue.
module wsfd_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [wsfd_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [wsfd_pkg::SAMPLE_BITS-1:0] right_in,
	input  logic [15:0]                            drive_gain,
	output logic                                   q_push,
	output wsfd_pkg::q_entry_t                     q_entry,
	input  logic                                   q_full
);

	localparam int SB = wsfd_pkg::SAMPLE_BITS;
	localparam int VW = wsfd_pkg::VW;
	localparam int DW = SB + 17;
	localparam logic signed [VW+1:0] ONE1 = (VW+2)'(wsfd_pkg::ONE);
	localparam logic signed [VW+1:0] ONE2 = (VW+2)'(2 * wsfd_pkg::ONE);

	logic                 valid_s1;
	logic signed [SB-1:0] x_l_s1;
	logic signed [SB-1:0] x_r_s1;
	logic                 valid_s2;
	logic signed [VW-1:0] v_l_s2;
	logic signed [VW-1:0] v_r_s2;
	logic                 adv2;

	// v = floor((x*gain + half) / 2^12)
	function automatic logic signed [VW-1:0] drive(input logic signed [SB-1:0] x,
		input logic [15:0] g);
		logic signed [DW-1:0] p;
		p = x * $signed({1'b0, g});
		return VW'((p + DW'(1 << (wsfd_pkg::DRIVE_FRAC - 1))) >>> wsfd_pkg::DRIVE_FRAC);
	endfunction

	// Region of 3v against ONE and 2*ONE
	function automatic wsfd_pkg::region_t classify(input logic signed [VW-1:0] v);
		logic signed [VW+1:0] t3;
		t3 = (VW+2)'(v) + ((VW+2)'(v) <<< 1);
		if (t3 > ONE2)
			return wsfd_pkg::RG_POS_SAT;
		else if (t3 > ONE1)
			return wsfd_pkg::RG_POS_CURVE;
		else if (t3 < -ONE2)
			return wsfd_pkg::RG_NEG_SAT;
		else if (t3 < -ONE1)
			return wsfd_pkg::RG_NEG_CURVE;
		return wsfd_pkg::RG_MID;
	endfunction

	assign adv2     = !valid_s2 || !q_full;
	assign in_stall = valid_s1 && !adv2;
	assign q_push   = valid_s2 && !q_full;

	always_comb begin
		q_entry.v_l  = v_l_s2;
		q_entry.v_r  = v_r_s2;
		q_entry.rg_l = classify(v_l_s2);
		q_entry.rg_r = classify(v_r_s2);
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			x_l_s1 <= left_in;
			x_r_s1 <= right_in;
		end
		if (adv2 && valid_s1) begin
			v_l_s2 <= drive(x_l_s1, drive_gain);
			v_r_s2 <= drive(x_r_s1, drive_gain);
		end
	end

endmodule

FILE: rtl/wsfd_queue.sv
// Short queue of driven frames between the front end and the back end.
// Depends on wsfd_pkg.
module wsfd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wsfd_pkg::q_entry_t push_entry,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output wsfd_pkg::q_entry_t pop_entry
);

	localparam int QD  = wsfd_pkg::Q_DEPTH;
	localparam int QAW = wsfd_pkg::QAW;

	wsfd_pkg::q_entry_t   mem_q [QD];
	logic [QAW-1:0]       wr_ptr_q;
	logic [QAW-1:0]       rd_ptr_q;
	logic [QAW:0]         count_q;

	assign full      = (count_q == (QAW+1)'(QD));
	assign valid     = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop)
				count_q <= count_q + (QAW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QAW+1)'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

FILE: rtl/wsfd_back.sv
// Back end: shaping curves, delay rings and mixing on one shared multiplier, one channel at a time.
// Depends on wsfd_pkg; fed by wsfd_queue.
module wsfd_back (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  wsfd_pkg::cfg_t                          cfg,
	input  logic                                    q_valid,
	input  wsfd_pkg::q_entry_t                      q_entry,
	output logic                                    q_pop,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [wsfd_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [wsfd_pkg::SAMPLE_BITS-1:0] right_out
);

	localparam int SB   = wsfd_pkg::SAMPLE_BITS;
	localparam int AW   = wsfd_pkg::AW;
	localparam int TAW  = wsfd_pkg::TAW;
	localparam int VW   = wsfd_pkg::VW;
	localparam int SW   = wsfd_pkg::SW;
	localparam int MA_W = wsfd_pkg::MA_W;
	localparam int MB_W = wsfd_pkg::MB_W;
	localparam int PW   = wsfd_pkg::PW;
	localparam int IW   = wsfd_pkg::IW;
	localparam int XS   = wsfd_pkg::IDX_SHIFT;
	localparam int MF   = wsfd_pkg::MIX_FRAC;
	localparam int DEPTH = wsfd_pkg::DELAY_DEPTH;

	localparam logic signed [SW-1:0]   ONE_S  = SW'(wsfd_pkg::ONE);
	localparam logic signed [VW+1:0]   ONE2   = (VW+2)'(2 * wsfd_pkg::ONE);
	localparam logic signed [PW:0]     ROUND  = (PW+1)'(1 << (MF - 1));
	localparam logic signed [PW:0]     SAT_HI = (PW+1)'(wsfd_pkg::ONE - 1);
	localparam logic signed [PW:0]     SAT_LO = -(PW+1)'(wsfd_pkg::ONE);

	wsfd_pkg::back_state_t state_q, state_d;
	logic                  ch_q, ch_d;
	logic [AW-1:0]         wp_q;
	logic [AW:0]           fill_q;
	logic                  out_valid_q;

	wsfd_pkg::q_entry_t    ent_q;
	logic                  dlv_q;
	logic signed [SB-1:0]  ring_l_q;
	logic signed [SB-1:0]  ring_r_q;
	logic [SB-1:0]         rom_q;
	logic [SB-1:0]         t0_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [PW-1:0]  acc_q;
	logic signed [SW-1:0]  s_q;
	logic signed [SB-1:0]  o_l_q;
	logic signed [SB-1:0]  o_r_q;
	logic signed [SB-1:0]  left_out_q;
	logic signed [SB-1:0]  right_out_q;

	logic signed [SB-1:0]  ring_l [DEPTH];
	logic signed [SB-1:0]  ring_r [DEPTH];

	// Control outputs of the sequencer
	logic                   mul_en;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic [TAW-1:0]         rom_addr;
	logic                   ring_re;
	logic                   ring_we;
	logic                   out_load;

	// Per-channel operands
	logic signed [VW-1:0]   vc;
	wsfd_pkg::region_t      rc;
	logic [VW-1:0]          a_mag;
	logic                   exp_neg;
	logic [IW-1:0]          idx;
	logic                   ovf;
	logic [TAW-1:0]         addr0;
	logic [TAW-1:0]         addr1;
	logic [15:0]            f16;
	logic signed [VW+1:0]   t3;
	logic signed [VW+1:0]   d_full;
	logic signed [PW-1:0]   q_sh;
	logic signed [SB:0]     diff;
	logic signed [SW-1:0]   exp_r;
	logic signed [SW-1:0]   shaped;
	logic signed [SB-1:0]   dl_c;
	logic signed [PW:0]     mix_sum;
	logic signed [PW:0]     st_sum;
	logic signed [SB-1:0]   mix_out;
	logic signed [SB-1:0]   st_val;
	logic [AW-1:0]          rd_addr;

	function automatic logic signed [SB-1:0] sat(input logic signed [PW:0] x);
		if (x > SAT_HI)
			return SB'(SAT_HI);
		else if (x < SAT_LO)
			return SB'(SAT_LO);
		return SB'(x);
	endfunction

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// Read position trails the write position by the delay, modulo the ring
	assign rd_addr = wp_q - AW'(cfg.delay_samples);

	// Operands of the channel in work
	always_comb begin
		vc      = ch_q ? ent_q.v_r : ent_q.v_l;
		rc      = ch_q ? ent_q.rg_r : ent_q.rg_l;
		a_mag   = (vc > 0) ? VW'(vc) : VW'(-vc);
		exp_neg = (vc <= 0);
		idx     = a_mag[VW-1:XS];
		ovf     = (idx >= IW'(wsfd_pkg::EXP_TABLE_DEPTH));
		addr0   = ovf ? TAW'(wsfd_pkg::EXP_TABLE_DEPTH) : TAW'(idx);
		addr1   = ovf ? TAW'(wsfd_pkg::EXP_TABLE_DEPTH) : TAW'(idx) + TAW'(1);
		f16     = ovf ? 16'd0 : a_mag[XS-1 -: 16];
		t3      = (VW+2)'(vc) + ((VW+2)'(vc) <<< 1);
		d_full  = (rc == wsfd_pkg::RG_NEG_CURVE) ? ONE2 + t3 : ONE2 - t3;
		q_sh    = (prod_q + PW'(wsfd_pkg::Q_BIAS)) >>> (SB - 1);
		diff    = $signed({1'b0, rom_q}) - $signed({1'b0, t0_q});
		exp_r   = SW'($signed({1'b0, t0_q})) + SW'(prod_q >>> 16);
		dl_c    = !dlv_q ? '0 : (ch_q ? ring_r_q : ring_l_q);
	end

	// Shaping curve, settled once the table and products are in
	always_comb begin
		case (cfg.distortion_mode)
			wsfd_pkg::MODE_FULL: shaped = (vc < 0) ? -SW'(vc) : SW'(vc);
			wsfd_pkg::MODE_HALF: shaped = (vc <= 0) ? '0 : SW'(vc);
			wsfd_pkg::MODE_HARD: begin
				if (SW'(vc) > ONE_S)
					shaped = ONE_S;
				else if (SW'(vc) < -ONE_S)
					shaped = -ONE_S;
				else
					shaped = SW'(vc);
			end
			wsfd_pkg::MODE_QUAD: begin
				case (rc)
					wsfd_pkg::RG_POS_SAT:   shaped = ONE_S;
					wsfd_pkg::RG_POS_CURVE: shaped = ONE_S - SW'(prod_q >>> wsfd_pkg::RECIP_SHIFT);
					wsfd_pkg::RG_NEG_CURVE: shaped = SW'(prod_q >>> wsfd_pkg::RECIP_SHIFT) - ONE_S;
					wsfd_pkg::RG_NEG_SAT:   shaped = -ONE_S;
					default:                shaped = SW'(vc) <<< 1;
				endcase
			end
			wsfd_pkg::MODE_EXP:  shaped = exp_neg ? -exp_r : exp_r;
			default:             shaped = SW'(vc);
		endcase
	end

	// Mix and ring-store sums
	always_comb begin
		mix_sum = (PW+1)'(acc_q) + (PW+1)'(prod_q) + ROUND;
		st_sum  = ((PW+1)'(s_q) <<< MF) + (PW+1)'(prod_q) + ROUND;
		mix_out = sat(mix_sum >>> MF);
		st_val  = sat(st_sum >>> MF);
	end

	// Sequencer: next state and datapath control
	always_comb begin
		state_d  = state_q;
		ch_d     = ch_q;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		rom_addr = addr0;
		ring_re  = 1'b0;
		ring_we  = 1'b0;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			wsfd_pkg::B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = wsfd_pkg::B_LOAD;
				end
			end
			wsfd_pkg::B_LOAD: begin
				ring_re = 1'b1;
				ch_d    = 1'b0;
				state_d = wsfd_pkg::B_SH0;
			end
			wsfd_pkg::B_SH0: begin
				rom_addr = addr0;
				if (cfg.distortion_mode == wsfd_pkg::MODE_QUAD) begin
					mul_en = 1'b1;
					mul_a  = MA_W'(d_full);
					mul_b  = MB_W'(d_full);
				end
				state_d = wsfd_pkg::B_SH1;
			end
			wsfd_pkg::B_SH1: begin
				rom_addr = addr1;
				if (cfg.distortion_mode == wsfd_pkg::MODE_QUAD) begin
					mul_en = 1'b1;
					mul_a  = MA_W'(q_sh);
					mul_b  = MB_W'(wsfd_pkg::RECIP3);
				end
				state_d = wsfd_pkg::B_SH2;
			end
			wsfd_pkg::B_SH2: begin
				if (cfg.distortion_mode == wsfd_pkg::MODE_EXP) begin
					mul_en = 1'b1;
					mul_a  = MA_W'(diff);
					mul_b  = MB_W'($signed({1'b0, f16}));
				end
				state_d = wsfd_pkg::B_SH3;
			end
			wsfd_pkg::B_SH3: begin
				if (cfg.delay_enable)
					state_d = wsfd_pkg::B_MIX0;
				else if (ch_q)
					state_d = wsfd_pkg::B_DONE;
				else begin
					ch_d    = 1'b1;
					state_d = wsfd_pkg::B_SH0;
				end
			end
			wsfd_pkg::B_MIX0: begin
				mul_en  = 1'b1;
				mul_a   = s_q;
				mul_b   = MB_W'($signed({1'b0, cfg.dry_mix}));
				state_d = wsfd_pkg::B_MIX1;
			end
			wsfd_pkg::B_MIX1: begin
				mul_en  = 1'b1;
				mul_a   = MA_W'(dl_c);
				mul_b   = MB_W'($signed({1'b0, cfg.wet_mix}));
				state_d = wsfd_pkg::B_MIX2;
			end
			wsfd_pkg::B_MIX2: begin
				mul_en  = 1'b1;
				mul_a   = MA_W'(dl_c);
				mul_b   = MB_W'($signed({1'b0, cfg.feedback_gain}));
				state_d = wsfd_pkg::B_MIX3;
			end
			wsfd_pkg::B_MIX3: begin
				ring_we = 1'b1;
				if (ch_q)
					state_d = wsfd_pkg::B_DONE;
				else begin
					ch_d    = 1'b1;
					state_d = wsfd_pkg::B_SH0;
				end
			end
			wsfd_pkg::B_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = wsfd_pkg::B_IDLE;
				end
			end
			default: state_d = wsfd_pkg::B_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wsfd_pkg::B_IDLE;
			ch_q        <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (out_load && cfg.delay_enable) begin
				wp_q <= wp_q + AW'(1);
				if (!fill_q[AW])
					fill_q <= fill_q + (AW+1)'(1);
			end
		end
	end

	// Shared multiplier
	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
	end

	// Curve table, registered read
	always_ff @(posedge clk) begin
		rom_q <= wsfd_pkg::EXP_TAB[rom_addr];
	end

	// Delay rings: read at the trailing position, write at the head
	always_ff @(posedge clk) begin
		if (ring_we && !ch_q)
			ring_l[wp_q] <= st_val;
		if (ring_re)
			ring_l_q <= ring_l[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ring_we && ch_q)
			ring_r[wp_q] <= st_val;
		if (ring_re)
			ring_r_q <= ring_r[rd_addr];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			wsfd_pkg::B_IDLE: begin
				if (q_pop)
					ent_q <= q_entry;
			end
			wsfd_pkg::B_LOAD: begin
				// entries not yet written since reset read as zero
				dlv_q <= fill_q[AW] || ((AW+1)'(rd_addr) < fill_q);
			end
			wsfd_pkg::B_SH1: t0_q <= rom_q;
			wsfd_pkg::B_SH3: begin
				s_q <= shaped;
				if (!cfg.delay_enable) begin
					if (ch_q)
						o_r_q <= sat((PW+1)'(shaped));
					else
						o_l_q <= sat((PW+1)'(shaped));
				end
			end
			wsfd_pkg::B_MIX1: acc_q <= prod_q;
			wsfd_pkg::B_MIX2: begin
				if (ch_q)
					o_r_q <= mix_out;
				else
					o_l_q <= mix_out;
			end
			wsfd_pkg::B_DONE: begin
				if (out_load) begin
					left_out_q  <= o_l_q;
					right_out_q <= o_r_q;
				end
			end
			default: ;
		endcase
	end

	// Fill count never passes the ring depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (AW+1)'(DEPTH))
		else $error("fill count beyond ring depth");

	// Until the ring has wrapped, the head equals the number of frames stored
	a_head_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_q[AW] |-> (wp_q == fill_q[AW-1:0]))
		else $error("write position out of step with fill count");

	// Both channels are finished before a frame is released
	a_done_ch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsfd_pkg::B_DONE) |-> ch_q)
		else $error("frame released with right channel unfinished");

	// A released frame shows up on the output next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

FILE: rtl/waveshaper_feedback_delay.sv
// Top level of the stereo waveshaper with feedback delay: register bank and the three parts.
// Depends on wsfd_pkg, wsfd_front, wsfd_queue and wsfd_back.
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_stall   left_in, right_in (signed 24)
// out      source     out_valid / out_stall left_out, right_out (signed 24)
// cfg      sink       cfg_valid / cfg_ready cfg_index (3), cfg_data (17)
//
// A frame passes front-end registers s1 and s2, then the back-end steps LOAD, SH0-SH3 and,
// with the delay on, MIX0-MIX3 per channel, then DONE: both channels share one multiplier.
// The rings are not cleared: a fill counter marks entries not yet written, which read as zero.
// The 4-entry queue keeps the input open while the back end works; the output register holds
// a stalled result while the back end finishes the next frame.
module waveshaper_feedback_delay (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [wsfd_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [wsfd_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [wsfd_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [wsfd_pkg::SAMPLE_BITS-1:0] right_out,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [wsfd_pkg::CFG_IW-1:0]             cfg_index,
	input  logic [wsfd_pkg::CFG_DW-1:0]             cfg_data
);

	wsfd_pkg::cfg_t     cfg_q;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_valid;
	wsfd_pkg::q_entry_t q_push_entry;
	wsfd_pkg::q_entry_t q_pop_entry;

	assign cfg_ready = 1'b1;

	// Register bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distortion_mode <= 3'd1;
			cfg_q.drive_gain      <= 16'd4096;
			cfg_q.delay_enable    <= 1'b0;
			cfg_q.delay_samples   <= 17'd24000;
			cfg_q.dry_mix         <= 16'd16384;
			cfg_q.wet_mix         <= 16'd16384;
			cfg_q.feedback_gain   <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wsfd_pkg::CFG_MODE:     cfg_q.distortion_mode <= cfg_data[2:0];
				wsfd_pkg::CFG_DRIVE:    cfg_q.drive_gain      <= cfg_data[15:0];
				wsfd_pkg::CFG_DLY_EN:   cfg_q.delay_enable    <= cfg_data[0];
				wsfd_pkg::CFG_DLY_LEN:  cfg_q.delay_samples   <= cfg_data[16:0];
				wsfd_pkg::CFG_DRY:      cfg_q.dry_mix         <= cfg_data[15:0];
				wsfd_pkg::CFG_WET:      cfg_q.wet_mix         <= cfg_data[15:0];
				wsfd_pkg::CFG_FEEDBACK: cfg_q.feedback_gain   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	wsfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.left_in    (left_in),
		.right_in   (right_in),
		.drive_gain (cfg_q.drive_gain),
		.q_push     (q_push),
		.q_entry    (q_push_entry),
		.q_full     (q_full)
	);

	wsfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.pop_entry  (q_pop_entry)
	);

	wsfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_entry   (q_pop_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out)
	);

endmodule
